/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// shared sizes, codes and types of the bitmap sector allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int TABLE_WORDS   = 64;
    localparam int WORD_BITS     = 32;
    localparam int TOTAL_SECTORS = TABLE_WORDS * WORD_BITS;
    localparam int WIDX_W        = $clog2(TABLE_WORDS);
    localparam int POS_W         = $clog2(WORD_BITS);
    localparam int CNT_W         = $clog2(TOTAL_SECTORS) + 1;
    localparam int DATA_W        = 32;
    localparam int SSZ_W         = 17;
    localparam int KIND_W        = 2;
    localparam int STAT_W        = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR = 1'b1;

    localparam logic [SSZ_W-1:0] SECTOR_RESET = 17'd512;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_REALLOC = 2'd1,
        KIND_FREE    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_ZERO  = 2'd2,
        STAT_RANGE = 2'd3
    } t_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DECIDE,
        S_SRCH,
        S_RNG_RD,
        S_RNG_WB,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DSEL_NEW,
        DSEL_OLD,
        DSEL_OFF
    } t_dsel;

    typedef enum logic [1:0] {
        ROP_SET,
        ROP_CLR,
        ROP_CHK
    } t_rop;

    typedef enum logic [2:0] {
        RN_ZERO,
        RN_OFFSET,
        RN_CHECKED,
        RN_MOVE,
        RN_MUL
    } t_rnext;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] run;
    } t_fit;

endpackage

/* design/bsa_ram.sv */
// ----------------------------------------------------------------------------
// bsa_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bsa_div.sv */
// ----------------------------------------------------------------------------
// bsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bsa_pkg::DATA_W-1:0] i_dividend,
    input  logic [bsa_pkg::SSZ_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [bsa_pkg::DATA_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(bsa_pkg::DATA_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_cnt;
    logic [bsa_pkg::SSZ_W-1:0]  r_rem;
    logic [bsa_pkg::SSZ_W-1:0]  r_div;
    logic [bsa_pkg::DATA_W-1:0] r_quot;
    logic [bsa_pkg::SSZ_W:0]    trial;
    logic                       fits;
    logic [bsa_pkg::SSZ_W-1:0]  n_rem;
    logic [bsa_pkg::DATA_W-1:0] n_quot;

    always_comb begin
        trial  = {r_rem, r_quot[bsa_pkg::DATA_W-1]};
        fits   = trial >= {1'b0, r_div};
        n_rem  = fits ? bsa_pkg::SSZ_W'(trial - {1'b0, r_div})
                      : trial[bsa_pkg::SSZ_W-1:0];
        n_quot = {r_quot[bsa_pkg::DATA_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(bsa_pkg::DATA_W - 1);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/bsa_fit.sv */
// ----------------------------------------------------------------------------
// bsa_fit
// first-fit test of one bitmap word against a carried free run
// ----------------------------------------------------------------------------
module bsa_fit (
    input  logic [bsa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bsa_pkg::CNT_W-1:0]     i_run,
    input  logic [bsa_pkg::CNT_W-1:0]     i_need,
    output bsa_pkg::t_fit                 o_fit
);

    logic [bsa_pkg::WORD_BITS-1:0] top;
    logic [bsa_pkg::WORD_BITS-1:0] hits;
    logic [bsa_pkg::WORD_BITS-1:0] win;
    logic [bsa_pkg::POS_W-1:0]     last_used;

    // top: the upper min(need, word) bits set; shifted down it is the run window
    always_comb begin
        if (i_need >= bsa_pkg::CNT_W'(bsa_pkg::WORD_BITS)) begin
            top = '1;
        end else begin
            top = ~({bsa_pkg::WORD_BITS{1'b1}} >> i_need[bsa_pkg::POS_W-1:0]);
        end
        for (int j = 0; j < bsa_pkg::WORD_BITS; j++) begin
            win     = top >> (bsa_pkg::WORD_BITS - 1 - j);
            hits[j] = ((i_word & win) == '0)
                      && (i_need <= i_run + bsa_pkg::CNT_W'(j + 1));
        end
        o_fit.hit = |hits;
        o_fit.pos = '0;
        for (int j = bsa_pkg::WORD_BITS - 1; j >= 0; j--) begin
            if (hits[j]) begin
                o_fit.pos = bsa_pkg::POS_W'(j);
            end
        end
        last_used = '0;
        for (int j = 0; j < bsa_pkg::WORD_BITS; j++) begin
            if (i_word[j]) begin
                last_used = bsa_pkg::POS_W'(j);
            end
        end
        if (i_word == '0) begin
            o_fit.run = i_run + bsa_pkg::CNT_W'(bsa_pkg::WORD_BITS);
        end else begin
            o_fit.run = bsa_pkg::CNT_W'(bsa_pkg::WORD_BITS - 1)
                        - bsa_pkg::CNT_W'(last_used);
        end
    end

endmodule

/* design/bitmap_sector_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_sector_allocator
// first-fit sector allocator over a bitmap held in a word-wide ram
// ----------------------------------------------------------------------------
//  channel   dir  fields (lowest bit first)
//  s_axis    in   tuser: kind; tdata: offset, old_size, new_size
//  m_axis    out  tuser: status; tdata: result_offset, moved, moved_from
//  cfg       in   i_cfg_addr 0 allocation_base, 1 sector_size
//
//  one request at a time: zero size and unused kinds go straight to the result;
//  allocate needs one division, free two, reallocate three, then as needed a
//  first-fit scan of one bitmap word per cycle and run updates of each word
//  touched (ram read, then write back)
//  reset starts a clearing pass of the bitmap with s_axis_tready low
//  a stalled result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module bitmap_sector_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [95:0]                  s_axis_tdata,  // offset, old_size, new_size
    input  logic [bsa_pkg::KIND_W-1:0]   s_axis_tuser,  // kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [71:0]                  m_axis_tdata,  // result_offset, moved, moved_from
    output logic [bsa_pkg::STAT_W-1:0]   m_axis_tuser,  // status
    input  logic                         i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [bsa_pkg::DATA_W-1:0]   i_cfg_wdata
);

    localparam int DW  = bsa_pkg::DATA_W;
    localparam int CW  = bsa_pkg::CNT_W;
    localparam int WB  = bsa_pkg::WORD_BITS;
    localparam int XW  = bsa_pkg::WIDX_W;
    localparam int PW  = bsa_pkg::POS_W;
    localparam logic [DW:0] TOTAL33 = (DW+1)'(bsa_pkg::TOTAL_SECTORS);

    // configuration
    logic [DW-1:0]              r_base,  n_base;
    logic [bsa_pkg::SSZ_W-1:0]  r_ssize, n_ssize;
    logic [bsa_pkg::SSZ_W-1:0]  eff;

    // request and intermediate values
    bsa_pkg::t_state r_state, n_state;
    bsa_pkg::t_kind  r_kind,  n_kind;
    bsa_pkg::t_dsel  r_dsel,  n_dsel;
    bsa_pkg::t_rop   r_rop,   n_rop;
    bsa_pkg::t_rnext r_rnext, n_rnext;
    bsa_pkg::t_stat  r_stat,  n_stat;
    logic [DW-1:0]   r_offset, n_offset;
    logic [DW-1:0]   r_old,    n_old;
    logic [DW-1:0]   r_new,    n_new;
    logic [DW:0]     r_need,   n_need;    // sectors asked for
    logic [DW:0]     r_have,   n_have;    // sectors of the existing run
    logic [DW-1:0]   r_sidx,   n_sidx;    // first sector of the existing run
    logic [XW:0]     r_widx,   n_widx;    // word pointer for clear, scan and update
    logic            r_ev_valid, n_ev_valid;
    logic [XW-1:0]   r_ev_idx, n_ev_idx;
    logic [CW-1:0]   r_run,    n_run;     // free sectors ending at the last word
    logic [CW-1:0]   r_start,  n_start;   // sector found by the scan
    logic [CW-1:0]   r_ra,     n_ra;      // run update range [ra, re)
    logic [CW-1:0]   r_re,     n_re;
    logic            r_free,   n_free;
    logic [DW-1:0]   r_res,    n_res;
    logic            r_moved,  n_moved;

    // output register
    logic            r_ovalid, n_ovalid;
    bsa_pkg::t_stat  r_ostat,  n_ostat;
    logic [DW-1:0]   r_ores,   n_ores;
    logic            r_omoved, n_omoved;
    logic [DW-1:0]   r_ofrom,  n_ofrom;

    // handshake and field views
    logic            s_acc;
    bsa_pkg::t_kind  in_kind;
    logic [DW-1:0]   in_off, in_old, in_new;

    // memory, divider, fit
    logic            ram_we;
    logic [XW-1:0]   ram_addr;
    logic [WB-1:0]   ram_wdata;
    logic [WB-1:0]   ram_rdata;
    logic            div_start;
    logic [DW-1:0]   div_arg;
    logic            div_done;
    logic [DW-1:0]   div_quot;
    logic [DW:0]     quot_p1;
    bsa_pkg::t_fit   fit;

    // helpers
    logic [CW-1:0]   need12, have12, s12;
    logic [DW:0]     room33;
    logic            loc_fits;
    logic [WB-1:0]   rng_mask;
    logic [CW-1:0]   rng_end_m1;
    logic            rng_last;
    logic            free_now;
    logic [CW-1:0]   found_start;
    logic            go_rng, go_srch;
    logic [CW-1:0]   go_a, go_len;
    bsa_pkg::t_rop   go_op;
    bsa_pkg::t_rnext go_next;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign in_kind = bsa_pkg::t_kind'(s_axis_tuser);
    assign in_off  = s_axis_tdata[31:0];
    assign in_old  = s_axis_tdata[63:32];
    assign in_new  = s_axis_tdata[95:64];

    // a zero sector size acts as one
    assign eff = (r_ssize == '0) ? bsa_pkg::SSZ_W'(1) : r_ssize;

    bsa_ram #(
        .WIDTH (WB),
        .DEPTH (bsa_pkg::TABLE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_arg),
        .i_divisor  (eff),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    bsa_fit u_fit (
        .i_word (ram_rdata),
        .i_run  (r_run),
        .i_need (need12),
        .o_fit  (fit)
    );

    // shared datapath terms
    always_comb begin
        quot_p1  = {1'b0, div_quot} + (DW+1)'(1);
        need12   = r_need[CW-1:0];
        have12   = r_have[CW-1:0];
        s12      = r_sidx[CW-1:0];
        room33   = TOTAL33 - (DW+1)'(s12);
        // existing run must start and end inside the table
        loc_fits = ({1'b0, div_quot} < TOTAL33)
                   && (r_have <= TOTAL33 - {1'b0, div_quot});
        // bits of the current word that fall in [ra, re)
        for (int i = 0; i < WB; i++) begin
            rng_mask[i] = (CW'({r_widx[XW-1:0], PW'(i)}) >= r_ra)
                          && (CW'({r_widx[XW-1:0], PW'(i)}) < r_re);
        end
        rng_end_m1  = r_re - CW'(1);
        rng_last    = r_widx[XW-1:0] == rng_end_m1[PW +: XW];
        free_now    = r_free && !((r_rop == bsa_pkg::ROP_CHK)
                                  && ((ram_rdata & rng_mask) != '0));
        found_start = CW'({r_ev_idx, fit.pos}) + CW'(1) - need12;
        case (r_dsel)
            bsa_pkg::DSEL_NEW: div_arg = r_new - DW'(1);
            bsa_pkg::DSEL_OLD: div_arg = r_old - DW'(1);
            default:           div_arg = r_offset - r_base;
        endcase
    end

    // next state and next register values
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_ssize    = r_ssize;
        n_kind     = r_kind;
        n_dsel     = r_dsel;
        n_rop      = r_rop;
        n_rnext    = r_rnext;
        n_stat     = r_stat;
        n_offset   = r_offset;
        n_old      = r_old;
        n_new      = r_new;
        n_need     = r_need;
        n_have     = r_have;
        n_sidx     = r_sidx;
        n_widx     = r_widx;
        n_ev_valid = r_ev_valid;
        n_ev_idx   = r_ev_idx;
        n_run      = r_run;
        n_start    = r_start;
        n_ra       = r_ra;
        n_re       = r_re;
        n_free     = r_free;
        n_res      = r_res;
        n_moved    = r_moved;
        n_ovalid   = r_ovalid;
        n_ostat    = r_ostat;
        n_ores     = r_ores;
        n_omoved   = r_omoved;
        n_ofrom    = r_ofrom;
        go_rng     = 1'b0;
        go_srch    = 1'b0;
        go_a       = '0;
        go_len     = '0;
        go_op      = bsa_pkg::ROP_SET;
        go_next    = bsa_pkg::RN_ZERO;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bsa_pkg::CFG_BASE:   n_base  = i_cfg_wdata;
                bsa_pkg::CFG_SECTOR: n_ssize = i_cfg_wdata[bsa_pkg::SSZ_W-1:0];
                default: ;
            endcase
        end

        // output register drains independently of the request in flight
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            bsa_pkg::S_CLEAR: begin
                n_widx = r_widx + 1'b1;
                if (r_widx[XW-1:0] == XW'(bsa_pkg::TABLE_WORDS - 1)) begin
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_kind   = in_kind;
                    n_offset = in_off;
                    n_old    = in_old;
                    n_new    = in_new;
                    n_stat   = bsa_pkg::STAT_OK;
                    n_res    = '0;
                    n_moved  = 1'b0;
                    unique case (in_kind)
                        bsa_pkg::KIND_ALLOC: begin
                            if (in_new == '0) begin
                                n_stat  = bsa_pkg::STAT_ZERO;
                                n_state = bsa_pkg::S_DONE;
                            end else begin
                                n_dsel  = bsa_pkg::DSEL_NEW;
                                n_state = bsa_pkg::S_DIV_GO;
                            end
                        end
                        bsa_pkg::KIND_FREE: begin
                            if (in_old == '0) begin
                                n_stat  = bsa_pkg::STAT_ZERO;
                                n_state = bsa_pkg::S_DONE;
                            end else begin
                                n_dsel  = bsa_pkg::DSEL_OLD;
                                n_state = bsa_pkg::S_DIV_GO;
                            end
                        end
                        bsa_pkg::KIND_REALLOC: begin
                            if (in_old == '0 || in_new == '0) begin
                                n_stat  = bsa_pkg::STAT_ZERO;
                                n_state = bsa_pkg::S_DONE;
                            end else begin
                                n_dsel  = bsa_pkg::DSEL_NEW;
                                n_state = bsa_pkg::S_DIV_GO;
                            end
                        end
                        default: n_state = bsa_pkg::S_DONE;
                    endcase
                end
            end
            bsa_pkg::S_DIV_GO: begin
                n_state = bsa_pkg::S_DIV_WAIT;
            end
            bsa_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    unique case (r_dsel)
                        bsa_pkg::DSEL_NEW: begin
                            n_need = quot_p1;
                            if (r_kind == bsa_pkg::KIND_ALLOC) begin
                                if (quot_p1 > TOTAL33) begin
                                    n_stat  = bsa_pkg::STAT_OOM;
                                    n_state = bsa_pkg::S_DONE;
                                end else begin
                                    go_srch = 1'b1;
                                end
                            end else begin
                                n_dsel  = bsa_pkg::DSEL_OLD;
                                n_state = bsa_pkg::S_DIV_GO;
                            end
                        end
                        bsa_pkg::DSEL_OLD: begin
                            n_have = quot_p1;
                            if (r_offset < r_base) begin
                                n_stat  = bsa_pkg::STAT_RANGE;
                                n_state = bsa_pkg::S_DONE;
                            end else begin
                                n_dsel  = bsa_pkg::DSEL_OFF;
                                n_state = bsa_pkg::S_DIV_GO;
                            end
                        end
                        default: begin
                            n_sidx = div_quot;
                            if (loc_fits) begin
                                n_state = bsa_pkg::S_DECIDE;
                            end else begin
                                n_stat  = bsa_pkg::STAT_RANGE;
                                n_state = bsa_pkg::S_DONE;
                            end
                        end
                    endcase
                end
            end
            bsa_pkg::S_DECIDE: begin
                if (r_kind == bsa_pkg::KIND_FREE) begin
                    go_rng  = 1'b1;
                    go_a    = s12;
                    go_len  = have12;
                    go_op   = bsa_pkg::ROP_CLR;
                    go_next = bsa_pkg::RN_ZERO;
                end else if (r_need == r_have) begin
                    n_res   = r_offset;
                    n_state = bsa_pkg::S_DONE;
                end else if (r_need < r_have) begin
                    // shrink: release the tail of the run
                    go_rng  = 1'b1;
                    go_a    = s12 + need12;
                    go_len  = have12 - need12;
                    go_op   = bsa_pkg::ROP_CLR;
                    go_next = bsa_pkg::RN_OFFSET;
                end else if (r_need <= room33) begin
                    // grow: first check the sectors behind the run
                    go_rng  = 1'b1;
                    go_a    = s12 + have12;
                    go_len  = need12 - have12;
                    go_op   = bsa_pkg::ROP_CHK;
                    go_next = bsa_pkg::RN_CHECKED;
                end else if (r_need > TOTAL33) begin
                    n_stat  = bsa_pkg::STAT_OOM;
                    n_state = bsa_pkg::S_DONE;
                end else begin
                    go_srch = 1'b1;
                end
            end
            bsa_pkg::S_SRCH: begin
                n_ev_valid = r_widx < (XW+1)'(bsa_pkg::TABLE_WORDS);
                n_ev_idx   = r_widx[XW-1:0];
                n_widx     = r_widx + 1'b1;
                if (r_ev_valid) begin
                    n_run = fit.run;
                    if (fit.hit) begin
                        n_start = found_start;
                        go_rng  = 1'b1;
                        go_a    = found_start;
                        go_len  = need12;
                        go_op   = bsa_pkg::ROP_SET;
                        go_next = (r_kind == bsa_pkg::KIND_ALLOC) ? bsa_pkg::RN_MUL
                                                                   : bsa_pkg::RN_MOVE;
                    end else if (r_ev_idx == XW'(bsa_pkg::TABLE_WORDS - 1)) begin
                        n_stat  = bsa_pkg::STAT_OOM;
                        n_state = bsa_pkg::S_DONE;
                    end
                end
            end
            bsa_pkg::S_RNG_RD: begin
                n_state = bsa_pkg::S_RNG_WB;
            end
            bsa_pkg::S_RNG_WB: begin
                n_free = free_now;
                if (!rng_last) begin
                    n_widx  = r_widx + 1'b1;
                    n_state = bsa_pkg::S_RNG_RD;
                end else begin
                    unique case (r_rnext)
                        bsa_pkg::RN_ZERO: n_state = bsa_pkg::S_DONE;
                        bsa_pkg::RN_OFFSET: begin
                            n_res   = r_offset;
                            n_state = bsa_pkg::S_DONE;
                        end
                        bsa_pkg::RN_CHECKED: begin
                            if (free_now) begin
                                go_rng  = 1'b1;
                                go_a    = s12 + have12;
                                go_len  = need12 - have12;
                                go_op   = bsa_pkg::ROP_SET;
                                go_next = bsa_pkg::RN_OFFSET;
                            end else if (r_need > TOTAL33) begin
                                n_stat  = bsa_pkg::STAT_OOM;
                                n_state = bsa_pkg::S_DONE;
                            end else begin
                                go_srch = 1'b1;
                            end
                        end
                        bsa_pkg::RN_MOVE: begin
                            // new run is marked, now release the old one
                            n_moved = 1'b1;
                            go_rng  = 1'b1;
                            go_a    = s12;
                            go_len  = have12;
                            go_op   = bsa_pkg::ROP_CLR;
                            go_next = bsa_pkg::RN_MUL;
                        end
                        default: n_state = bsa_pkg::S_MUL;
                    endcase
                end
            end
            bsa_pkg::S_MUL: begin
                n_res   = r_base + DW'(r_start) * DW'(eff);
                n_state = bsa_pkg::S_DONE;
            end
            bsa_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_stat;
                    n_ores   = r_res;
                    n_omoved = r_moved;
                    n_ofrom  = r_moved ? r_offset : '0;
                    n_state  = bsa_pkg::S_IDLE;
                end
            end
            default: n_state = bsa_pkg::S_IDLE;
        endcase

        if (go_rng) begin
            n_ra    = go_a;
            n_re    = go_a + go_len;
            n_widx  = {1'b0, go_a[PW +: XW]};
            n_free  = 1'b1;
            n_rop   = go_op;
            n_rnext = go_next;
            n_state = bsa_pkg::S_RNG_RD;
        end
        if (go_srch) begin
            n_widx     = '0;
            n_ev_valid = 1'b0;
            n_run      = '0;
            n_state    = bsa_pkg::S_SRCH;
        end
    end

    // memory, divider and handshake controls
    always_comb begin
        ram_we        = 1'b0;
        ram_addr      = r_widx[XW-1:0];
        ram_wdata     = '0;
        div_start     = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            bsa_pkg::S_CLEAR:  ram_we = 1'b1;
            bsa_pkg::S_IDLE:   s_axis_tready = 1'b1;
            bsa_pkg::S_DIV_GO: div_start = 1'b1;
            bsa_pkg::S_RNG_WB: begin
                case (r_rop)
                    bsa_pkg::ROP_SET: begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | rng_mask;
                    end
                    bsa_pkg::ROP_CLR: begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~rng_mask;
                    end
                    default: ram_we = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsa_pkg::S_CLEAR;
            r_widx     <= '0;
            r_ev_valid <= 1'b0;
            r_ovalid   <= 1'b0;
            r_base     <= '0;
            r_ssize    <= bsa_pkg::SECTOR_RESET;
        end else begin
            r_state    <= n_state;
            r_widx     <= n_widx;
            r_ev_valid <= n_ev_valid;
            r_ovalid   <= n_ovalid;
            r_base     <= n_base;
            r_ssize    <= n_ssize;
        end
        r_kind   <= n_kind;
        r_dsel   <= n_dsel;
        r_rop    <= n_rop;
        r_rnext  <= n_rnext;
        r_stat   <= n_stat;
        r_offset <= n_offset;
        r_old    <= n_old;
        r_new    <= n_new;
        r_need   <= n_need;
        r_have   <= n_have;
        r_sidx   <= n_sidx;
        r_ev_idx <= n_ev_idx;
        r_run    <= n_run;
        r_start  <= n_start;
        r_ra     <= n_ra;
        r_re     <= n_re;
        r_free   <= n_free;
        r_res    <= n_res;
        r_moved  <= n_moved;
        r_ostat  <= n_ostat;
        r_ores   <= n_ores;
        r_omoved <= n_omoved;
        r_ofrom  <= n_ofrom;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tdata  = {7'b0, r_ofrom, r_omoved, r_ores};

endmodule

/* design/bsa_chk.sv */
// ----------------------------------------------------------------------------
// bsa_chk
// port-level checks of the bitmap sector allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [95:0]                   s_axis_tdata,
    input logic [bsa_pkg::KIND_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [71:0]                   m_axis_tdata,
    input logic [bsa_pkg::STAT_W-1:0]    m_axis_tuser,
    input logic                          i_cfg_we,
    input logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input logic [bsa_pkg::DATA_W-1:0]    i_cfg_wdata
);

    // stalled result beat holds
    `BSA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // one request in flight: busy right after a beat is taken
    `BSA_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

    // a failed request reports no offset and no move
    `BSA_ASSERT_IMP(a_fail_clean, m_axis_tvalid && (m_axis_tuser != bsa_pkg::STAT_OK), (m_axis_tdata[31:0] == '0) && !m_axis_tdata[32], "failed request carries an offset")

    // old offset only reported with a move
    `BSA_ASSERT_IMP(a_from_moved, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[64:33] == '0, "moved_from set without a move")

endmodule

bind bitmap_sector_allocator bsa_chk u_bsa_chk (.*);
